/* rtl/twg_pkg.sv */
package twg_pkg;

  // Default geometry of the phase accumulators and of the sine table.
  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned PHASE_WIDTH_DEF = 32;

  // Fixed field widths.
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned AMP_W      = 15;
  localparam int unsigned LEN_W      = 24;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned MAG_W      = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned NUM_VOICES = 3;

  // Waveform modes.
  typedef enum logic [1:0] {
    MODE_SINE   = 2'd0,
    MODE_SQUARE = 2'd1,
    MODE_SWEEP  = 2'd2,
    MODE_CHORD  = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TONE_STEP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_STEP    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP_RATE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_LENGTH = 3'd6;

  // Reset values of the configuration registers.
  localparam logic [STEP_W-1:0] TONE_STEP_RST   = 32'd21424231;
  localparam logic [STEP_W-1:0] SECOND_STEP_RST = 32'd25480126;
  localparam logic [STEP_W-1:0] THIRD_STEP_RST  = 32'd32103452;
  localparam logic [AMP_W-1:0]  AMPLITUDE_RST   = 15'd30000;
  localparam logic [LEN_W-1:0]  LENGTH_RST      = 24'd44100;

  // Pi over two in Q30 and the full-scale table value.
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] FULL_SCALE  = 64'd32767;

  // Divides a Taylor term by (2n)(2n+1).
  function automatic logic [63:0] taylor_div(input logic [63:0] t, input int unsigned n);
    logic [63:0] r;
    case (n)
      1:       r = t / 64'd6;
      2:       r = t / 64'd20;
      3:       r = t / 64'd42;
      4:       r = t / 64'd72;
      5:       r = t / 64'd110;
      6:       r = t / 64'd156;
      default: r = t / 64'd210;
    endcase
    return r;
  endfunction

  // Magnitude of the sine at quarter-wave position q of a table of
  // 2^depth_log2 entries. Evaluated at elaboration only.
  function automatic logic [MAG_W-1:0] sine_quarter_mag(input int unsigned q,
                                                         input int unsigned depth_log2);
    logic [63:0]        a;
    logic [63:0]        x;
    logic [63:0]        t;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    a   = 64'(q) << 2;
    x   = (HALF_PI_Q30 * a) >> depth_log2;
    sum = signed'(x);
    t   = x;
    for (int unsigned n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = taylor_div(t, n);
      if (n[0]) begin
        sum = sum - signed'(t);
      end else begin
        sum = sum + signed'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (unsigned'(sum) * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (mag > FULL_SCALE) begin
      mag = FULL_SCALE;
    end
    return mag[MAG_W-1:0];
  endfunction

endpackage

/* rtl/twg_phase.sv */
module twg_phase #(
  parameter int unsigned TABLE_DEPTH = twg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PHASE_WIDTH = twg_pkg::PHASE_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic                                   restart_i,
  input  twg_pkg::mode_e                         mode_i,
  input  logic [twg_pkg::STEP_W-1:0]             tone_step_i,
  input  logic [twg_pkg::STEP_W-1:0]             second_step_i,
  input  logic [twg_pkg::STEP_W-1:0]             third_step_i,
  input  logic signed [twg_pkg::STEP_W-1:0]      sweep_rate_i,
  input  logic [twg_pkg::LEN_W-1:0]              sample_length_i,
  output logic [twg_pkg::NUM_VOICES-1:0]         neg_o,
  output logic [twg_pkg::NUM_VOICES-1:0][$clog2(TABLE_DEPTH)-2:0] quarter_o,
  output logic                                   last_o
);

  localparam int unsigned IdxW       = $clog2(TABLE_DEPTH);
  localparam int unsigned QW         = IdxW - 1;
  localparam int unsigned PW         = PHASE_WIDTH;
  localparam int unsigned LenW       = twg_pkg::LEN_W;
  localparam int unsigned StepW      = twg_pkg::STEP_W;
  localparam int unsigned NumVoices  = twg_pkg::NUM_VOICES;
  localparam logic [IdxW-1:0] HalfDepth  = IdxW'(TABLE_DEPTH / 2);
  localparam logic [QW-1:0]   QuarterMax = QW'(TABLE_DEPTH / 4);

  logic [NumVoices-1:0][PW-1:0] phase_q, phase_d, phase_cur, voice_step;
  logic [StepW-1:0]             step_q, step_d, step_cur;
  logic [LenW-1:0]              index_q, index_d, index_cur, len_eff;
  logic                         run_end;
  logic [NumVoices-1:0]         neg_d;
  logic [NumVoices-1:0][QW-1:0] quarter_d;
  logic [IdxW-1:0]              tab_idx;
  logic [QW-1:0]                half_pos;

  // Phase, step and sample counter update for the request being accepted.
  always_comb begin
    for (int v = 0; v < NumVoices; v++) begin
      phase_cur[v] = restart_i ? '0 : phase_q[v];
    end
    index_cur = restart_i ? '0 : index_q;
    step_cur  = (index_cur == '0) ? tone_step_i : step_q;
    len_eff   = (sample_length_i == '0) ? LenW'(1) : sample_length_i;
    run_end   = ({1'b0, index_cur} + (LenW + 1)'(1)) >= {1'b0, len_eff};

    voice_step[0] = PW'((mode_i == twg_pkg::MODE_SWEEP) ? step_cur : tone_step_i);
    voice_step[1] = PW'(second_step_i);
    voice_step[2] = PW'(third_step_i);

    phase_d = phase_q;
    index_d = index_q;
    step_d  = step_q;
    if (accept_i) begin
      for (int v = 0; v < NumVoices; v++) begin
        phase_d[v] = run_end ? '0 : phase_cur[v] + voice_step[v];
      end
      index_d = run_end ? '0 : index_cur + LenW'(1);
      step_d  = (mode_i == twg_pkg::MODE_SWEEP) ? step_cur + unsigned'(sweep_rate_i)
                                                : step_cur;
    end
  end

  // Fold each table index onto the first quarter wave and keep the sign.
  always_comb begin
    tab_idx  = '0;
    half_pos = '0;
    for (int v = 0; v < NumVoices; v++) begin
      tab_idx      = phase_cur[v][PW-1 -: IdxW];
      half_pos     = tab_idx[IdxW-2:0];
      neg_d[v]     = tab_idx[IdxW-1];
      quarter_d[v] = (half_pos > QuarterMax) ? QW'(HalfDepth - {1'b0, half_pos}) : half_pos;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      step_q  <= '0;
      index_q <= '0;
    end else begin
      phase_q <= phase_d;
      step_q  <= step_d;
      index_q <= index_d;
    end
  end

  // Lookup addresses and the end-of-run flag for the next stage.
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      neg_o     <= neg_d;
      quarter_o <= quarter_d;
      last_o    <= run_end;
    end
  end

endmodule

/* rtl/twg_voice.sv */
module twg_voice #(
  parameter int unsigned TABLE_DEPTH = twg_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic                                neg_i,
  input  logic [$clog2(TABLE_DEPTH)-2:0]      quarter_i,
  input  logic [twg_pkg::AMP_W-1:0]           amplitude_i,
  output logic signed [twg_pkg::SAMPLE_W-1:0] value_o,
  output logic                                positive_o
);

  localparam int unsigned IdxW         = $clog2(TABLE_DEPTH);
  localparam int unsigned QuarterDepth = TABLE_DEPTH / 4 + 1;
  localparam int unsigned MagW         = twg_pkg::MAG_W;
  localparam int unsigned AmpW         = twg_pkg::AMP_W;
  localparam int unsigned SampleW      = twg_pkg::SAMPLE_W;
  localparam int unsigned ProdW        = MagW + AmpW;

  wire  [MagW-1:0]           quarter_rom [QuarterDepth];
  logic [MagW-1:0]           mag;
  logic [ProdW-1:0]          prod;
  logic [SampleW-1:0]        scaled;
  logic signed [SampleW-1:0] value_d;

  // Quarter-wave sine magnitudes, built at elaboration.
  for (genvar gi = 0; gi < QuarterDepth; gi++) begin : g_rom
    localparam logic [MagW-1:0] Entry = twg_pkg::sine_quarter_mag(gi, IdxW);
    assign quarter_rom[gi] = Entry;
  end

  // Scale the magnitude by the amplitude, truncating toward zero, then apply the sign.
  always_comb begin
    mag     = quarter_rom[quarter_i];
    prod    = ProdW'(mag) * ProdW'(amplitude_i);
    scaled  = SampleW'(prod[ProdW-1:AmpW]);
    value_d = neg_i ? -signed'(scaled) : signed'(scaled);
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      value_o    <= value_d;
      positive_o <= !neg_i && (mag != '0);
    end
  end

endmodule

/* rtl/twg_mix.sv */
module twg_mix (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  twg_pkg::mode_e                      mode_i,
  input  logic [twg_pkg::AMP_W-1:0]           amplitude_i,
  input  logic signed [twg_pkg::SAMPLE_W-1:0] value_i [twg_pkg::NUM_VOICES],
  input  logic                                positive_i,
  input  logic                                last_i,
  output logic signed [twg_pkg::SAMPLE_W-1:0] sample_o,
  output logic                                last_o
);

  localparam int unsigned SampleW   = twg_pkg::SAMPLE_W;
  localparam int unsigned SumW      = SampleW + 2;
  localparam int unsigned NumVoices = twg_pkg::NUM_VOICES;

  logic signed [SumW-1:0]    sum;
  logic signed [SampleW-1:0] chord;
  logic signed [SampleW-1:0] square;
  logic signed [SampleW-1:0] sample_d;

  // Chord sum with saturation to the sample range.
  always_comb begin
    sum = '0;
    for (int v = 0; v < NumVoices; v++) begin
      sum = sum + SumW'(value_i[v]);
    end
    if (sum[SumW-1:SampleW-1] == '0 || sum[SumW-1:SampleW-1] == '1) begin
      chord = sum[SampleW-1:0];
    end else if (sum[SumW-1]) begin
      chord = {1'b1, {(SampleW - 1){1'b0}}};
    end else begin
      chord = {1'b0, {(SampleW - 1){1'b1}}};
    end
  end

  // Select the output by waveform mode.
  always_comb begin
    square = positive_i ? signed'(SampleW'(amplitude_i)) : -signed'(SampleW'(amplitude_i));
    case (mode_i)
      twg_pkg::MODE_SQUARE: sample_d = square;
      twg_pkg::MODE_CHORD:  sample_d = chord;
      twg_pkg::MODE_SINE:   sample_d = value_i[0];
      twg_pkg::MODE_SWEEP:  sample_d = value_i[0];
      default:              sample_d = value_i[0];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      sample_o <= sample_d;
      last_o   <= last_i;
    end
  end

endmodule

/* rtl/tone_waveform_generator.sv */
// Direct digital synthesis tone generator. Each accepted request (with an
// optional restart flag) produces one signed 16-bit sample and a last flag
// that marks the final sample of a run of sample_length samples. Up to three
// phase accumulators address a quarter-wave sine table that is computed at
// elaboration; TABLE_DEPTH must be a power of two. The block takes one request
// per cycle and sustains one sample per cycle while the output is not stalled;
// a sample passes through the phase stage, the table and multiply stage, and
// the mix and output register. The phase accumulator update is the loop that
// sets the rate. Configuration registers must be written only while no sample
// is in flight.
module tone_waveform_generator #(
  parameter int unsigned TABLE_DEPTH = twg_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned PHASE_WIDTH = twg_pkg::PHASE_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [twg_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [twg_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  restart_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [twg_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                  last_o
);

  localparam int unsigned QW        = $clog2(TABLE_DEPTH) - 1;
  localparam int unsigned NumVoices = twg_pkg::NUM_VOICES;
  localparam int unsigned StepW     = twg_pkg::STEP_W;
  localparam int unsigned AmpW      = twg_pkg::AMP_W;
  localparam int unsigned LenW      = twg_pkg::LEN_W;
  localparam int unsigned SampleW   = twg_pkg::SAMPLE_W;

  twg_pkg::mode_e           mode_q;
  logic [StepW-1:0]         tone_step_q, second_step_q, third_step_q;
  logic signed [StepW-1:0]  sweep_rate_q;
  logic [AmpW-1:0]          amplitude_q;
  logic [LenW-1:0]          sample_length_q;

  logic                         a_valid_q, b_valid_q, out_valid_q;
  logic                         out_free, b_move, b_free, a_move, accept;
  logic [NumVoices-1:0]         a_neg;
  logic [NumVoices-1:0][QW-1:0] a_quarter;
  logic                         a_last, b_last_q;
  logic signed [SampleW-1:0]    b_value [NumVoices];
  logic [NumVoices-1:0]         b_positive;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= twg_pkg::MODE_SINE;
      tone_step_q     <= twg_pkg::TONE_STEP_RST;
      second_step_q   <= twg_pkg::SECOND_STEP_RST;
      third_step_q    <= twg_pkg::THIRD_STEP_RST;
      sweep_rate_q    <= '0;
      amplitude_q     <= twg_pkg::AMPLITUDE_RST;
      sample_length_q <= twg_pkg::LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        twg_pkg::REG_MODE:          mode_q          <= twg_pkg::mode_e'(cfg_data_i[1:0]);
        twg_pkg::REG_TONE_STEP:     tone_step_q     <= cfg_data_i[StepW-1:0];
        twg_pkg::REG_SECOND_STEP:   second_step_q   <= cfg_data_i[StepW-1:0];
        twg_pkg::REG_THIRD_STEP:    third_step_q    <= cfg_data_i[StepW-1:0];
        twg_pkg::REG_SWEEP_RATE:    sweep_rate_q    <= signed'(cfg_data_i[StepW-1:0]);
        twg_pkg::REG_AMPLITUDE:     amplitude_q     <= cfg_data_i[AmpW-1:0];
        twg_pkg::REG_SAMPLE_LENGTH: sample_length_q <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: each stage advances when the next one is free.
  assign out_free   = !out_valid_q || out_ready_i;
  assign b_move     = b_valid_q && out_free;
  assign b_free     = !b_valid_q || out_free;
  assign a_move     = a_valid_q && b_free;
  assign in_ready_o = !a_valid_q || b_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (a_move) begin
        a_valid_q <= 1'b0;
      end
      if (a_move) begin
        b_valid_q <= 1'b1;
      end else if (b_move) begin
        b_valid_q <= 1'b0;
      end
      if (b_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  // The end-of-run flag rides alongside the table stage.
  always_ff @(posedge clk_i) begin
    if (a_move) begin
      b_last_q <= a_last;
    end
  end

  twg_phase #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .PHASE_WIDTH (PHASE_WIDTH)
  ) u_phase (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .restart_i       (restart_i),
    .mode_i          (mode_q),
    .tone_step_i     (tone_step_q),
    .second_step_i   (second_step_q),
    .third_step_i    (third_step_q),
    .sweep_rate_i    (sweep_rate_q),
    .sample_length_i (sample_length_q),
    .neg_o           (a_neg),
    .quarter_o       (a_quarter),
    .last_o          (a_last)
  );

  for (genvar gv = 0; gv < NumVoices; gv++) begin : g_voice
    twg_voice #(
      .TABLE_DEPTH (TABLE_DEPTH)
    ) u_voice (
      .clk_i       (clk_i),
      .load_i      (a_move),
      .neg_i       (a_neg[gv]),
      .quarter_i   (a_quarter[gv]),
      .amplitude_i (amplitude_q),
      .value_o     (b_value[gv]),
      .positive_o  (b_positive[gv])
    );
  end

  twg_mix u_mix (
    .clk_i       (clk_i),
    .load_i      (b_move),
    .mode_i      (mode_q),
    .amplitude_i (amplitude_q),
    .value_i     (b_value),
    .positive_i  (b_positive[0]),
    .last_i      (b_last_q),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

endmodule

/* rtl/twg_checker.sv */
module twg_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [twg_pkg::SAMPLE_W-1:0] sample_o,
  input logic                                last_o
);

  // A stalled result keeps its sample and flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(sample_o) && $stable(last_o))
    else $error("result changed or dropped while stalled");

  // The block only refuses requests when the output side is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("request refused while the output side is free");

  // With the output side open, a result shows once its request has passed the phase, table and mix registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o ##1 out_ready_i ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after its request");

  // Nothing is shown right after reset.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid straight after reset");

endmodule

bind tone_waveform_generator twg_checker u_twg_checker (.*);

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Timing and sizing of the run.
  localparam int    CLK_HALF     = 6;
  localparam int    RESET_CYCLES = 12;
  localparam int    PIPE_DEPTH   = 3;
  localparam int    ROM_DEPTH    = 1024;
  localparam int    PHASE_ITEMS  = 450;
  localparam longint TIMEOUT_NS  = 5_000_000;

  // Q30 value of pi over two used to build the sine table.
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned PEAK_CODE        = 64'd32767;

  // Register index that decodes to no register.
  localparam logic [twg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [twg_pkg::SAMPLE_W-1:0] sample;
    logic                                last;
  } sample_t;

  // Block ports.
  logic                                 clk_i = 1'b0;
  logic                                 rst_ni;
  logic                                 cfg_we_i;
  logic [twg_pkg::CFG_IDX_W-1:0]        cfg_idx_i;
  logic [twg_pkg::CFG_DATA_W-1:0]       cfg_data_i;
  logic                                 in_valid_i;
  logic                                 in_ready_o;
  logic                                 restart_i;
  logic                                 out_valid_o;
  logic                                 out_ready_i = 1'b0;
  logic signed [twg_pkg::SAMPLE_W-1:0]  sample_o;
  logic                                 last_o;

  // Expected samples, oldest first.
  sample_t pending_samples[$];

  // Shadow of the configuration registers.
  twg_pkg::mode_e                reg_mode;
  logic [twg_pkg::STEP_W-1:0]    reg_tone;
  logic [twg_pkg::STEP_W-1:0]    reg_second;
  logic [twg_pkg::STEP_W-1:0]    reg_third;
  logic [twg_pkg::STEP_W-1:0]    reg_rate;
  logic [twg_pkg::AMP_W-1:0]     reg_amp;
  logic [twg_pkg::LEN_W-1:0]     reg_len;

  // Shadow of the generator state.
  logic [31:0]                   gen_phase [twg_pkg::NUM_VOICES];
  logic [twg_pkg::STEP_W-1:0]    gen_step;
  logic [twg_pkg::LEN_W-1:0]     gen_count;

  int sine_rom [ROM_DEPTH];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int requests_sent  = 0;
  int samples_checked = 0;
  int runs_ended     = 0;
  int reg_writes     = 0;

  tone_waveform_generator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sample_o    (sample_o),
    .last_o      (last_o)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // One full-wave table entry: fold to the first quadrant, then sum the
  // Taylor series through the fifteenth power in Q30.
  function automatic int sine_code(int unsigned k);
    longint unsigned a;
    longint unsigned x;
    longint unsigned t;
    longint unsigned mag;
    longint unsigned n;
    longint          sum;
    bit              neg;
    a   = 64'(k) * 4;
    neg = 1'b0;
    if (a >= 2 * ROM_DEPTH) begin
      neg = 1'b1;
      a   = a - 2 * ROM_DEPTH;
    end
    if (a > ROM_DEPTH) begin
      a = 2 * ROM_DEPTH - a;
    end
    x   = (QUARTER_TURN_Q30 * a) / ROM_DEPTH;
    sum = longint'(x);
    t   = x;
    for (n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / ((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - longint'(t);
      end else begin
        sum = sum + longint'(t);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    mag = (longint'(sum) * PEAK_CODE + (64'd1 << 29)) >> 30;
    if (mag > PEAK_CODE) begin
      mag = PEAK_CODE;
    end
    return neg ? -int'(mag) : int'(mag);
  endfunction

  // Table value times amplitude, truncated toward zero.
  function automatic int scale_voice(int s);
    int unsigned m;
    int unsigned p;
    m = (s < 0) ? -s : s;
    p = (m * 32'(reg_amp)) >> 15;
    return (s < 0) ? -int'(p) : int'(p);
  endfunction

  function automatic int table_at(logic [31:0] phase);
    return sine_rom[phase[31:22]];
  endfunction

  // Put the shadow registers and state at their reset values.
  task automatic reset_shadow();
    reg_mode   = twg_pkg::MODE_SINE;
    reg_tone   = twg_pkg::TONE_STEP_RST;
    reg_second = twg_pkg::SECOND_STEP_RST;
    reg_third  = twg_pkg::THIRD_STEP_RST;
    reg_rate   = '0;
    reg_amp    = twg_pkg::AMPLITUDE_RST;
    reg_len    = twg_pkg::LENGTH_RST;
    for (int v = 0; v < twg_pkg::NUM_VOICES; v++) begin
      gen_phase[v] = '0;
    end
    gen_step  = '0;
    gen_count = '0;
  endtask

  // Work out the sample for one accepted request and advance the state.
  task automatic advance_generator(logic restart);
    sample_t                    exp_s;
    int                         s0;
    int                         res;
    logic [twg_pkg::LEN_W-1:0]  len;
    logic [twg_pkg::LEN_W:0]    next_count;
    logic [twg_pkg::STEP_W-1:0] step0;
    if (restart) begin
      for (int v = 0; v < twg_pkg::NUM_VOICES; v++) begin
        gen_phase[v] = '0;
      end
      gen_step  = '0;
      gen_count = '0;
    end
    if (gen_count == '0) begin
      gen_step = reg_tone;
    end

    s0 = table_at(gen_phase[0]);
    case (reg_mode)
      twg_pkg::MODE_SQUARE: begin
        res = (s0 > 0) ? int'(reg_amp) : -int'(reg_amp);
      end
      twg_pkg::MODE_CHORD: begin
        res = scale_voice(s0) + scale_voice(table_at(gen_phase[1]))
            + scale_voice(table_at(gen_phase[2]));
        if (res > 32767) begin
          res = 32767;
        end
        if (res < -32768) begin
          res = -32768;
        end
      end
      default: begin
        res = scale_voice(s0);
      end
    endcase

    // A zero length behaves as a run of one sample.
    len        = (reg_len == '0) ? twg_pkg::LEN_W'(1) : reg_len;
    next_count = {1'b0, gen_count} + 1'b1;
    exp_s.last = (next_count >= {1'b0, len});
    exp_s.sample = res[twg_pkg::SAMPLE_W-1:0];

    step0 = (reg_mode == twg_pkg::MODE_SWEEP) ? gen_step : reg_tone;
    if (exp_s.last) begin
      for (int v = 0; v < twg_pkg::NUM_VOICES; v++) begin
        gen_phase[v] = '0;
      end
      gen_count = '0;
    end else begin
      gen_phase[0] = gen_phase[0] + step0;
      gen_phase[1] = gen_phase[1] + reg_second;
      gen_phase[2] = gen_phase[2] + reg_third;
      gen_count    = next_count[twg_pkg::LEN_W-1:0];
    end
    if (reg_mode == twg_pkg::MODE_SWEEP) begin
      gen_step = gen_step + reg_rate;
    end
    pending_samples.push_back(exp_s);
  endtask

  // Write one register; called at a falling edge while the block is idle.
  task automatic write_reg(logic [twg_pkg::CFG_IDX_W-1:0] idx,
                           logic [twg_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      twg_pkg::REG_MODE:          reg_mode   = twg_pkg::mode_e'(data[1:0]);
      twg_pkg::REG_TONE_STEP:     reg_tone   = data;
      twg_pkg::REG_SECOND_STEP:   reg_second = data;
      twg_pkg::REG_THIRD_STEP:    reg_third  = data;
      twg_pkg::REG_SWEEP_RATE:    reg_rate   = data;
      twg_pkg::REG_AMPLITUDE:     reg_amp    = data[twg_pkg::AMP_W-1:0];
      twg_pkg::REG_SAMPLE_LENGTH: reg_len    = data[twg_pkg::LEN_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Send one request; called at a falling edge, returns at a falling edge
  // with valid still high so that back-to-back requests need no toggle.
  task automatic send_request(logic restart);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      restart_i  <= 1'($urandom_range(0, 1));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i  <= restart;
    do begin
      @(posedge clk_i);
    end while (in_ready_o !== 1'b1);
    advance_generator(restart);
    requests_sent++;
    @(negedge clk_i);
  endtask

  // Drop valid and wait until every expected sample has come out.
  task automatic wait_until_idle();
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (PIPE_DEPTH + 1) @(negedge clk_i);
  endtask

  task automatic send_burst(int count, logic first_restart);
    for (int i = 0; i < count; i++) begin
      send_request((i == 0) ? first_restart : 1'b0);
    end
  endtask

  // A few samples straight out of reset with the default registers.
  task automatic test_reset_defaults();
    send_request(1'b0);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    wait_until_idle();
  endtask

  // Quarter-turn steps land the phases on zero, peak, half and trough, which
  // drives chord saturation both ways and the zero table value in square.
  task automatic test_waveform_extremes();
    write_reg(twg_pkg::REG_AMPLITUDE, 32'd32767);
    write_reg(twg_pkg::REG_TONE_STEP, 32'h4000_0000);
    write_reg(twg_pkg::REG_SECOND_STEP, 32'h4000_0000);
    write_reg(twg_pkg::REG_THIRD_STEP, 32'h4000_0000);
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, 32'd8);
    write_reg(twg_pkg::REG_MODE, 32'(twg_pkg::MODE_CHORD));
    send_burst(5, 1'b1);
    wait_until_idle();
    write_reg(twg_pkg::REG_MODE, 32'(twg_pkg::MODE_SQUARE));
    send_burst(4, 1'b1);
    wait_until_idle();
    // Zero amplitude silences sine; an oversized write is masked.
    write_reg(twg_pkg::REG_MODE, 32'(twg_pkg::MODE_SINE));
    write_reg(twg_pkg::REG_AMPLITUDE, 32'd0);
    send_burst(2, 1'b0);
    wait_until_idle();
    write_reg(twg_pkg::REG_AMPLITUDE, 32'hFFFF_FFFF);
    // Sweep with the largest step and both extreme rates, so the step wraps.
    write_reg(twg_pkg::REG_TONE_STEP, 32'hFFFF_FFFF);
    write_reg(twg_pkg::REG_SWEEP_RATE, 32'h7FFF_FFFF);
    write_reg(twg_pkg::REG_MODE, 32'(twg_pkg::MODE_SWEEP));
    send_burst(3, 1'b1);
    wait_until_idle();
    write_reg(twg_pkg::REG_SWEEP_RATE, 32'h8000_0000);
    send_burst(3, 1'b0);
    wait_until_idle();
  endtask

  // Run-length handling: zero length, masked length, an unused index and a
  // length lowered below the running count.
  task automatic test_run_length();
    write_reg(twg_pkg::REG_MODE, 32'hFFFF_FFFC);
    write_reg(twg_pkg::REG_TONE_STEP, 32'd21424231);
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, 32'd0);
    send_burst(2, 1'b0);
    wait_until_idle();
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, 32'hFF00_0003);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    send_burst(4, 1'b1);
    wait_until_idle();
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, 32'h00FF_FFFF);
    send_burst(4, 1'b1);
    wait_until_idle();
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, 32'd2);
    send_burst(2, 1'b0);
    wait_until_idle();
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h4000_0000 + $urandom_range(0, 3) - 1;
      3, 4:    return $urandom();
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom();
      default: return 32'($urandom_range(0, 200000)) - 32'd100000;
    endcase
  endfunction

  function automatic logic [31:0] pick_amplitude();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1, 2:    return 32'd32767;
      3, 4, 5: return $urandom();
      default: return $urandom_range(0, 32767);
    endcase
  endfunction

  // Short runs mostly, so that last and the phase restart come often.
  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 19))
      0, 1:    return 32'd0;
      2:       return {8'($urandom_range(0, 255)), 24'hFF_FFFF};
      3:       return $urandom();
      4, 5:    return $urandom_range(41, 300);
      default: return $urandom_range(1, 40);
    endcase
  endfunction

  task automatic write_random_config();
    write_reg(twg_pkg::REG_MODE, $urandom());
    write_reg(twg_pkg::REG_TONE_STEP, pick_step());
    write_reg(twg_pkg::REG_SECOND_STEP, pick_step());
    write_reg(twg_pkg::REG_THIRD_STEP, pick_step());
    write_reg(twg_pkg::REG_SWEEP_RATE, pick_rate());
    write_reg(twg_pkg::REG_AMPLITUDE, pick_amplitude());
    write_reg(twg_pkg::REG_SAMPLE_LENGTH, pick_length());
    if ($urandom_range(0, 7) == 0) begin
      write_reg(REG_UNUSED, $urandom());
    end
  endtask

  // Random segments, each with fresh registers, under one idling profile.
  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int sent;
    int seg_len;
    sent = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (sent < PHASE_ITEMS) begin
      write_random_config();
      seg_len = $urandom_range(20, 60);
      for (int i = 0; i < seg_len; i++) begin
        send_request(($urandom_range(0, 11) == 0) ||
                     (i == 0 && $urandom_range(0, 1) == 1));
      end
      sent += seg_len;
      wait_until_idle();
    end
  endtask

  // Receiver side: ready is redrawn at every falling edge.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare every accepted sample with the oldest expectation.
  always @(posedge clk_i) begin : check_output
    sample_t exp_s;
    if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
      if (pending_samples.size() == 0) begin
        $error("sample %0d arrived with nothing expected", sample_o);
        error_count++;
      end else begin
        exp_s = pending_samples.pop_front();
        if (sample_o !== exp_s.sample) begin
          $error("sample: expected %0d, got %0d", exp_s.sample, sample_o);
          error_count++;
        end
        if (last_o !== exp_s.last) begin
          $error("last: expected %0b, got %0b", exp_s.last, last_o);
          error_count++;
        end
        if (exp_s.last) begin
          runs_ended++;
        end
        samples_checked++;
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    restart_i  = 1'b0;
    for (int k = 0; k < ROM_DEPTH; k++) begin
      sine_rom[k] = sine_code(k);
    end
    reset_shadow();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_waveform_extremes();
    test_run_length();
    test_random_traffic(34, 50);
    test_random_traffic(50, 34);
    test_random_traffic(0, 0);

    wait_until_idle();
    repeat (4 * PIPE_DEPTH) @(negedge clk_i);
    if (pending_samples.size() != 0) begin
      $error("%0d expected samples never arrived", pending_samples.size());
      error_count++;
    end

    $display("Ran %0d requests through all four modes; %0d samples checked, %0d run ends.",
             requests_sent, samples_checked, runs_ended);
    $display("Made %0d register writes, including masked values and the unused index.",
             reg_writes);
    if (error_count == 0) begin
      $display("tone_waveform_generator test passed");
    end else begin
      $display("tone_waveform_generator test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("tone_waveform_generator test failed");
    $finish;
  end

endmodule
